// ===== hdl/ppg_pkg.sv =====
// ============================================================================
// ppg_pkg: shared constants for the plasma pixel generator
// Screen geometry, fixed-point constants, derived widths and stage positions.
// ============================================================================
package ppg_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int ANGLE_BITS    = 16;

  localparam int PIX_X_W = 10;
  localparam int PIX_Y_W = 9;
  localparam int FRAME_W = 16;
  localparam int INDEX_W = 8;
  localparam int COLOR_W = 24;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [31:0] K_RAD        = 32'd683565276;
  localparam logic [31:0] K_RING       = 32'd2670177;
  localparam logic [31:0] K_FRAME      = 32'd227855092;
  localparam logic [31:0] K_Y74        = 32'd9237369;
  localparam logic [31:0] K_X57        = 32'd11992373;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [15:0] SIN_MASK = (ANGLE_BITS >= 16) ? 16'hFFFF :
                                     16'(16'hFFFF << (16 - ANGLE_BITS));
  localparam int SIN_W   = 16;
  localparam int SIN_LAT = 4;

  localparam int HALF_W  = SCREEN_WIDTH / 2;
  localparam int HALF_H  = SCREEN_HEIGHT / 2;
  localparam int X_MAX   = (1 << PIX_X_W) - 1;
  localparam int Y_MAX   = (1 << PIX_Y_W) - 1;
  localparam int DX_MAX  = (HALF_W > X_MAX - HALF_W) ? HALF_W : X_MAX - HALF_W;
  localparam int DY_MAX  = (HALF_H > Y_MAX - HALF_H) ? HALF_H : Y_MAX - HALF_H;
  localparam int DX_W    = $clog2(((HALF_W > X_MAX) ? HALF_W : X_MAX) + 1) + 1;
  localparam int DY_W    = $clog2(((HALF_H > Y_MAX) ? HALF_H : Y_MAX) + 1) + 1;
  localparam int SQ_MAX  = DX_MAX * DX_MAX + DY_MAX * DY_MAX;
  localparam int SQ_W    = $clog2(SQ_MAX + 1);
  localparam int V_W     = SQ_W + 8;
  localparam int ROOT_W  = (V_W + 1) / 2;

  localparam int N_W     = PIX_X_W + 30 + 14;
  localparam int DEN_W   = 20;
  localparam int DEN_LOG = 18;
  localparam int Q_W     = N_W - DEN_LOG;

  localparam logic signed [21:0] DEN1_BASE = 22'sd606208;
  localparam logic signed [21:0] DEN2_BASE = 22'sd507904;

  localparam int TOT_W = 40;
  localparam logic signed [TOT_W-1:0] TOT_BIAS = 40'sd34359738368;

  localparam int ST_DEN      = 1 + SIN_LAT + 1;
  localparam int PIPE_DEPTH  = ST_DEN + Q_W + SIN_LAT + 2;
  localparam int S1_DLY      = (PIPE_DEPTH - 2) - (3 + ROOT_W + SIN_LAT);

endpackage

// ===== hdl/plasma_pixel_generator_top.sv =====
// ============================================================================
// plasma_pixel_generator_top: plasma effect palette index and color per pixel
// Ring term from the center distance plus a warped wave term, summed and
// saturated to an 8-bit index with its palette color.
// ============================================================================
// channel  | dir | fields (tdata, low bit first)
// s_axis   | in  | pix_x[9:0], pix_y[18:10], frame_count[34:19]
// m_axis   | out | color_index[7:0], pixel_color[31:8]
//
// One pixel per cycle while the skid register is empty; a result passes 48
// pipeline stages plus the output register, most of them in the 36-step divider.
// Reset clears the pipeline valid bits and the output and skid valid flags only.
// A stalled output parks one result in the skid register; the pipeline
// then holds until the skid register drains.
module plasma_pixel_generator_top import ppg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pix_x, pix_y, frame_count
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // color_index, pixel_color
);

  logic en;
  logic [PIPE_DEPTH:1] v_q;

  logic [PIX_X_W-1:0] pix_x;
  logic [PIX_Y_W-1:0] pix_y;
  logic [FRAME_W-1:0] frame_count;
  logic signed [DX_W-1:0] dx;
  logic signed [DY_W-1:0] dy;
  logic signed [2*DX_W-1:0] dx2;
  logic signed [2*DY_W-1:0] dy2;
  logic [SQ_W-1:0] sq_d;

  logic [31:0] ph_cy_q, ph_sx_q;
  logic [N_W-1:0] n1_q [1:ST_DEN-1];
  logic [N_W-1:0] n2_q [1:ST_DEN-1];
  logic signed [SIN_W-1:0] cy, sx;
  logic signed [21:0] d1_s, d2_s;

  logic [DEN_W-1:0] r1_q [0:Q_W];
  logic [DEN_W-1:0] r2_q [0:Q_W];
  logic [DEN_W-1:0] d1_q [0:Q_W];
  logic [DEN_W-1:0] d2_q [0:Q_W];
  logic [N_W-1:0]   dn1_q [0:Q_W];
  logic [N_W-1:0]   dn2_q [0:Q_W];
  logic [Q_W-1:0]   q1_q [0:Q_W];
  logic [Q_W-1:0]   q2_q [0:Q_W];

  logic [V_W-1:0]     rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0]  root_q [0:ROOT_W];
  logic [FRAME_W-1:0] fr_q   [0:ROOT_W];
  logic [31:0] pa_q, pb_q, ph1_q;
  logic signed [SIN_W-1:0] s1;
  logic signed [SIN_W-1:0] s1_q [1:S1_DLY];

  logic signed [SIN_W-1:0] a_s, b_s;
  logic signed [31:0] ab_q;
  logic signed [SIN_W-1:0] s1ab_q;
  logic signed [TOT_W-1:0] s1w, abw, tot_d, tot_q;

  logic [INDEX_W-1:0] idx;
  logic [OUT_DATA_W-1:0] res_d, out_data_q, skid_data_q;
  logic out_valid_q, skid_valid_q, pipe_push;

  assign en            = ~skid_valid_q;
  assign s_axis_tready = en & rst_ni;

  assign pix_x       = s_axis_tdata[PIX_X_W-1:0];
  assign pix_y       = s_axis_tdata[PIX_X_W+PIX_Y_W-1:PIX_X_W];
  assign frame_count = s_axis_tdata[PIX_X_W+PIX_Y_W+FRAME_W-1:PIX_X_W+PIX_Y_W];

  assign dx   = DX_W'(HALF_W) - DX_W'(pix_x);
  assign dy   = DY_W'(HALF_H) - DY_W'(pix_y);
  assign dx2  = dx * dx;
  assign dy2  = dy * dy;
  assign sq_d = SQ_W'(unsigned'(dx2)) + SQ_W'(unsigned'(dy2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-1:1], s_axis_tvalid};
    end
  end

  // front stage and carries
  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_cy_q   <= 32'(pix_y) * K_Y74;
      ph_sx_q   <= 32'(pix_x) * K_X57;
      n1_q[1]   <= (N_W'(pix_x) * N_W'(K_RAD)) << 14;
      n2_q[1]   <= (N_W'(pix_y) * N_W'(K_RAD)) << 14;
      rem_q[0]  <= V_W'(sq_d) << 8;
      root_q[0] <= '0;
      fr_q[0]   <= frame_count;
      for (int k = 2; k < ST_DEN; k++) begin
        n1_q[k] <= n1_q[k-1];
        n2_q[k] <= n2_q[k-1];
      end
    end
  end

  ppg_sine u_sine_cy (.clk_i, .en_i(en), .phase_i(ph_cy_q + QUARTER_TURN), .sine_o(cy));
  ppg_sine u_sine_sx (.clk_i, .en_i(en), .phase_i(ph_sx_q), .sine_o(sx));

  assign d1_s = DEN1_BASE + 22'(cy) * 22'sd15;
  assign d2_s = DEN2_BASE + 22'(sx) * 22'sd11;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0]  <= d1_s[DEN_W-1:0];
      d2_q[0]  <= d2_s[DEN_W-1:0];
      r1_q[0]  <= DEN_W'(n1_q[ST_DEN-1][N_W-1:Q_W]);
      r2_q[0]  <= DEN_W'(n2_q[ST_DEN-1][N_W-1:Q_W]);
      dn1_q[0] <= n1_q[ST_DEN-1];
      dn2_q[0] <= n2_q[ST_DEN-1];
      q1_q[0]  <= '0;
      q2_q[0]  <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_div
    logic [DEN_W:0] t1, t2;
    logic ge1, ge2;
    assign t1  = {r1_q[k-1], dn1_q[k-1][Q_W-k]};
    assign t2  = {r2_q[k-1], dn2_q[k-1][Q_W-k]};
    assign ge1 = t1 >= {1'b0, d1_q[k-1]};
    assign ge2 = t2 >= {1'b0, d2_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en) begin
        r1_q[k]  <= ge1 ? DEN_W'(t1 - {1'b0, d1_q[k-1]}) : DEN_W'(t1);
        r2_q[k]  <= ge2 ? DEN_W'(t2 - {1'b0, d2_q[k-1]}) : DEN_W'(t2);
        q1_q[k]  <= {q1_q[k-1][Q_W-2:0], ge1};
        q2_q[k]  <= {q2_q[k-1][Q_W-2:0], ge2};
        d1_q[k]  <= d1_q[k-1];
        d2_q[k]  <= d2_q[k-1];
        dn1_q[k] <= dn1_q[k-1];
        dn2_q[k] <= dn2_q[k-1];
      end
    end
  end

  // square root, one root bit per stage
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - k;
    logic [V_W:0] trial;
    logic take;
    assign trial = ((V_W+1)'(root_q[k-1]) << (B + 1)) + ((V_W+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_q[k-1]} >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[k]  <= take ? V_W'({1'b0, rem_q[k-1]} - trial) : rem_q[k-1];
        root_q[k] <= take ? (root_q[k-1] | (ROOT_W'(1) << B)) : root_q[k-1];
        fr_q[k]   <= fr_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q  <= 32'(root_q[ROOT_W]) * K_RING;
      pb_q  <= 32'(fr_q[ROOT_W]) * K_FRAME;
      ph1_q <= pa_q + pb_q;
    end
  end

  ppg_sine u_sine_ring (.clk_i, .en_i(en), .phase_i(ph1_q), .sine_o(s1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q[1] <= s1;
      for (int k = 2; k <= S1_DLY; k++) begin
        s1_q[k] <= s1_q[k-1];
      end
    end
  end

  ppg_sine u_sine_a (.clk_i, .en_i(en), .phase_i(q1_q[Q_W][31:0]), .sine_o(a_s));
  ppg_sine u_sine_b (.clk_i, .en_i(en), .phase_i(q2_q[Q_W][31:0] + QUARTER_TURN),
                     .sine_o(b_s));

  assign s1w   = TOT_W'(s1ab_q);
  assign abw   = TOT_W'(ab_q);
  assign tot_d = TOT_BIAS + ((s1w <<< 20) - (s1w <<< 14)) + ((abw <<< 6) - abw);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab_q   <= 32'(a_s) * 32'(b_s);
      s1ab_q <= s1_q[S1_DLY];
      tot_q  <= tot_d;
    end
  end

  always_comb begin
    if (tot_q[TOT_W-1]) begin
      idx = '0;
    end else if (|tot_q[TOT_W-2:36]) begin
      idx = '1;
    end else begin
      idx = tot_q[35:28];
    end
    res_d = {COLOR_W'({idx, 16'd0}) + (COLOR_W'(256) - COLOR_W'(idx)), idx};
  end

  assign pipe_push = en & v_q[PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= pipe_push;
      end
    end else if (pipe_push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_d;
    end else if (pipe_push) begin
      skid_data_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/ppg_sine.sv =====
// ============================================================================
// ppg_sine: pipelined fixed-point sine
// Phase as a fraction of a turn in, signed Q1.14 sine out, four stages.
// ============================================================================
module ppg_sine import ppg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [31:0]             phase_i,
  output logic signed [SIN_W-1:0] sine_o
);

  logic [15:0] p;
  logic [1:0]  quad;
  logic [14:0] f_d;
  logic [29:0] fsq;
  logic [25:0] m1;
  logic [28:0] m2;
  logic [29:0] m3;

  logic [1:0]  qa_q, qb_q, qc_q;
  logic [14:0] fa_q, fb_q, fc_q;
  logic [14:0] x2a_q, x2b_q;
  logic [13:0] t1_q;
  logic [14:0] t2_q;
  logic signed [SIN_W-1:0] s_q;

  assign p    = phase_i[31:16] & SIN_MASK;
  assign quad = p[15:14];
  assign f_d  = quad[0] ? 15'(15'd16384 - 15'(p[13:0])) : 15'(p[13:0]);
  assign fsq  = 30'(f_d) * 30'(f_d);
  assign m1   = 26'(x2a_q) * 26'd1232;
  assign m2   = 29'(t1_q) * 29'(x2b_q);
  assign m3   = 30'(t2_q) * 30'(fc_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qa_q  <= quad;
      fa_q  <= f_d;
      x2a_q <= fsq[28:14];
      qb_q  <= qa_q;
      fb_q  <= fa_q;
      x2b_q <= x2a_q;
      t1_q  <= 14'(14'd10584 - 14'(m1[25:14]));
      qc_q  <= qb_q;
      fc_q  <= fb_q;
      t2_q  <= 15'(15'd25736 - 15'(m2[28:14]));
      s_q   <= qc_q[1] ? -signed'(m3[29:14]) : signed'(m3[29:14]);
    end
  end

  assign sine_o = s_q;

endmodule
